// ----- sv/srr_pkg.sv -----
// Package: shared constants, codes and controller/datapath handshake types.
package srr_pkg;

  localparam int SEQ_COUNT_DEF  = 32;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int SEQ_W   = 6;
  localparam int WORD_W  = 32;
  localparam int RW_W    = 5;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 2;

  localparam int WINDOW_CAP = 16;
  localparam int CNT_W      = $clog2(WINDOW_CAP + 1);

  localparam logic [RW_W-1:0]   RW_RESET    = RW_W'(10);
  localparam logic [APB_AW-1:0] ADDR_RX_WIN = '0;

  typedef enum logic {
    KIND_DELIVER = 1'b0,
    KIND_ACK     = 1'b1
  } kind_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic scan_step;
    logic scan_done;
    logic read;
  } srr_cmd_t;

  typedef struct packed {
    logic run;
    logic scan_more;
    logic count_zero;
  } srr_stat_t;

endpackage

// ----- sv/srr_if.sv -----
// Interfaces: packet input channel and result output channel.
interface srr_pkt_if import srr_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SEQ_W-1:0]  packet_seq;
  logic [WORD_W-1:0] payload;

  modport source (output valid, packet_seq, payload, input ready);
  modport sink   (input valid, packet_seq, payload, output ready);
endinterface

interface srr_res_if import srr_pkg::*;;
  logic              valid;
  logic              ready;
  logic              result_kind;
  logic [WORD_W-1:0] delivered_word;
  logic [SEQ_W-1:0]  ack_seq;
  logic [SEQ_W-1:0]  expected_seq;
  logic              in_window;
  logic              bad_seq;
  logic              last;

  modport source (output valid, result_kind, delivered_word, ack_seq, expected_seq,
                  in_window, bad_seq, last, input ready);
  modport sink   (input valid, result_kind, delivered_word, ack_seq, expected_seq,
                  in_window, bad_seq, last, output ready);
endinterface

// ----- sv/srr_dpath.sv -----
// Datapath: slot store, valid marks, window check, run scan and delivery pointer.
module srr_dpath import srr_pkg::*; #(
  parameter int SEQ_COUNT  = SEQ_COUNT_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  srr_cmd_t          cmd,
  output srr_stat_t         st,
  input  logic [SEQ_W-1:0]  packet_seq,
  input  logic [WORD_W-1:0] payload,
  input  logic [RW_W-1:0]   rx_win,
  output logic [WORD_W-1:0] rd_word,
  output logic [SEQ_W-1:0]  seq_q,
  output logic [SEQ_W-1:0]  exp_q,
  output logic              inwin_q,
  output logic              bad_q
);

  localparam int SLOT_W  = (SEQ_COUNT > 1) ? $clog2(SEQ_COUNT) : 1;
  localparam int CMP_W   = SLOT_W + SEQ_W + 1;
  localparam int EXT_W   = DATA_WIDTH + WORD_W;
  // a run never laps the ring: stop at the cap or after every slot once
  localparam int RUN_CAP = (SEQ_COUNT < WINDOW_CAP) ? SEQ_COUNT : WINDOW_CAP;

  logic [DATA_WIDTH-1:0] mem [SEQ_COUNT];
  logic [SEQ_COUNT-1:0]  valid;
  logic [DATA_WIDTH-1:0] word_q;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [SLOT_W-1:0]     nexp;
  logic [SLOT_W-1:0]     scan_ptr;
  logic [CNT_W-1:0]      count;

  logic [EXT_W-1:0]      in_ext;
  logic [EXT_W-1:0]      out_ext;
  logic [CMP_W-1:0]      seq_ext;
  logic [SLOT_W-1:0]     slot;
  logic [SLOT_W:0]       diff;
  logic [SLOT_W:0]       ahead;
  logic [RW_W-1:0]       win;
  logic                  bad;
  logic                  inwin;

  function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] x);
    logic [SLOT_W-1:0] r;
    if (x == SLOT_W'(SEQ_COUNT - 1)) r = '0;
    else                             r = x + SLOT_W'(1);
    return r;
  endfunction

  function automatic logic [SEQ_W-1:0] one_based(input logic [SLOT_W-1:0] x);
    logic [CMP_W-1:0] s;
    s = CMP_W'(x) + CMP_W'(1);
    return s[SEQ_W-1:0];
  endfunction

  assign in_ext  = EXT_W'(payload);
  assign out_ext = EXT_W'(rd_data);
  assign rd_word = out_ext[WORD_W-1:0];

  // window check on the latched packet
  always_comb begin
    seq_ext = CMP_W'(seq_q);
    bad     = (seq_q == '0) || (seq_ext > CMP_W'(SEQ_COUNT));
    slot    = SLOT_W'(seq_ext - CMP_W'(1));
    diff    = {1'b0, slot} - {1'b0, nexp};
    if (slot >= nexp) ahead = diff;
    else              ahead = diff + (SLOT_W + 1)'(SEQ_COUNT);
    win     = (rx_win > RW_W'(WINDOW_CAP)) ? RW_W'(WINDOW_CAP) : rx_win;
    inwin   = !bad && (CMP_W'(ahead) < CMP_W'(win));
  end

  assign st.run        = inwin && (slot == nexp);
  assign st.scan_more  = valid[scan_ptr] && (count != CNT_W'(RUN_CAP));
  assign st.count_zero = (count == '0);

  // control state: marks and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      nexp  <= '0;
    end else begin
      if (cmd.eval && inwin && !valid[slot]) valid[slot] <= 1'b1;
      if (cmd.read) begin
        valid[nexp] <= 1'b0;
        nexp        <= wrap_inc(nexp);
      end
    end
  end

  // packet and run bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seq_q  <= packet_seq;
      word_q <= in_ext[DATA_WIDTH-1:0];
    end
    if (cmd.eval) begin
      inwin_q  <= inwin;
      bad_q    <= bad;
      exp_q    <= one_based(nexp);
      scan_ptr <= nexp;
      count    <= '0;
    end
    if (cmd.scan_step) begin
      count    <= count + CNT_W'(1);
      scan_ptr <= wrap_inc(scan_ptr);
    end
    if (cmd.scan_done) exp_q <= one_based(scan_ptr);
    if (cmd.read)      count <= count - CNT_W'(1);
  end

  // slot store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.eval && inwin && !valid[slot]) mem[slot] <= word_q;
    if (cmd.read) rd_data <= mem[nexp];
  end

endmodule

// ----- sv/srr_ctrl.sv -----
// Controller: sequences evaluate, scan, delivery and acknowledgement per packet.
module srr_ctrl import srr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output kind_t     out_kind,
  output srr_cmd_t  cmd,
  input  srr_stat_t st
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_READ,
    S_DELIV,
    S_ACK
  } state_t;

  state_t state;

  always_comb begin
    cmd           = '0;
    cmd.load      = (state == S_IDLE) && in_valid && in_ready;
    cmd.eval      = (state == S_EVAL);
    cmd.scan_step = (state == S_SCAN) && st.scan_more;
    cmd.scan_done = (state == S_SCAN) && !st.scan_more;
    cmd.read      = (state == S_READ);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
      out_kind  <= KIND_ACK;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= S_EVAL;
            in_ready <= 1'b0;
          end
        end
        S_EVAL: begin
          if (st.run) begin
            state <= S_SCAN;
          end else begin
            state     <= S_ACK;
            out_valid <= 1'b1;
            out_kind  <= KIND_ACK;
          end
        end
        S_SCAN: begin
          if (!st.scan_more) state <= S_READ;
        end
        S_READ: begin
          state     <= S_DELIV;
          out_valid <= 1'b1;
          out_kind  <= KIND_DELIVER;
        end
        S_DELIV: begin
          if (out_ready) begin
            if (st.count_zero) begin
              state    <= S_ACK;
              out_kind <= KIND_ACK;
            end else begin
              state     <= S_READ;
              out_valid <= 1'b0;
            end
          end
        end
        S_ACK: begin
          if (out_ready) begin
            state     <= S_IDLE;
            out_valid <= 1'b0;
            in_ready  <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/selective_repeat_receiver_top.sv -----
// Top level: selective-repeat receiver reorder window with APB window register.
// A packet beat is latched, then evaluated; with nothing released the ack beat follows.
// Otherwise the run is scanned, each released word is read from the store and presented
// as a delivery beat, and the ack beat comes last. The next packet is taken only after
// the ack beat is taken, so any output stall also holds the input.
// Reset (synchronous): valid marks clear, expected pointer 0, receive window 10.
module selective_repeat_receiver_top import srr_pkg::*; #(
  parameter int SEQ_COUNT  = SEQ_COUNT_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  srr_pkt_if.sink           pkt,
  srr_res_if.source         res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  srr_cmd_t          cmd;
  srr_stat_t         st;
  kind_t             kind;
  logic [RW_W-1:0]   rx_win;
  logic [WORD_W-1:0] rd_word;
  logic [SEQ_W-1:0]  seq_q;
  logic [SEQ_W-1:0]  exp_q;
  logic              inwin_q;
  logic              bad_q;

  // Config port: pready is held high, so no wait states; only the window register is decoded.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_RX_WIN) ? APB_DW'(rx_win) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_win <= RW_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_RX_WIN)) begin
      rx_win <= pwdata[RW_W-1:0];
    end
  end

  // Controller sequences each packet: evaluate, scan the run, deliver, ack.
  srr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pkt.valid),
    .in_ready  (pkt.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_kind  (kind),
    .cmd       (cmd),
    .st        (st)
  );

  // Datapath holds the slot store, marks and the expected pointer.
  srr_dpath #(
    .SEQ_COUNT  (SEQ_COUNT),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .packet_seq (pkt.packet_seq),
    .payload    (pkt.payload),
    .rx_win     (rx_win),
    .rd_word    (rd_word),
    .seq_q      (seq_q),
    .exp_q      (exp_q),
    .inwin_q    (inwin_q),
    .bad_q      (bad_q)
  );

  // Result beat: delivery beats carry the released word, the ack beat the echo.
  // expected_seq is final for the packet before its first beat goes out.
  assign res.result_kind    = kind;
  assign res.delivered_word = (kind == KIND_ACK) ? '0 : rd_word;
  assign res.ack_seq        = (kind == KIND_ACK) ? seq_q : '0;
  assign res.expected_seq   = exp_q;
  assign res.in_window      = inwin_q;
  assign res.bad_seq        = bad_q;
  assign res.last           = (kind == KIND_ACK);

endmodule
